>>> rtl/core/amq_pkg.sv
// ----------------------------------------------------------------------------
// amq_pkg
// Types and constants shared by the int8 absmax activation quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package amq_pkg;

    localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
    localparam logic [31:0] FP_EPS     = 32'h322B_CC77;
    localparam logic [31:0] FP_QMAX    = 32'h42FE_0000;
    localparam logic [7:0]  Q_POS_MAX  = 8'sd127;
    localparam logic [7:0]  Q_NEG_MAX  = -8'sd127;
    localparam logic        CMD_GATHER = 1'b0;
    localparam logic        CMD_QUANT  = 1'b1;

    // Classified item carried from the front to the back
    typedef struct packed {
        logic        cmd;
        logic [31:0] value;
        logic        first;
        logic        last;
        logic        is_nan;
        logic        is_inf;
        logic        is_tiny;
    } item_t;

    typedef struct packed {
        logic [7:0]  quantized;
        logic        sat_pos;
        logic        sat_neg;
        logic [31:0] scale_bits;
        logic        last_out;
    } result_t;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_DIV_SCALE,
        BK_DIV_INV
    } back_state_t;

endpackage

`default_nettype wire

>>> rtl/core/amq_fifo.sv
// ----------------------------------------------------------------------------
// amq_fifo
// Small register FIFO with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module amq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [WIDTH-1:0]           wr_data,
    output logic                            full,
    input  wire logic                       rd_en,
    output logic [WIDTH-1:0]                rd_data,
    output logic                            empty,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/amq_front.sv
// ----------------------------------------------------------------------------
// amq_front
// Accepts input items, classifies the element and queues it for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module amq_front #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic            command,
    input  wire logic [31:0]     value_bits,
    input  wire logic            first,
    input  wire logic            last,
    output logic                 item_valid,
    input  wire logic            item_pop,
    output amq_pkg::item_t       item
);

    import amq_pkg::*;

    item_t                      cls;
    logic [$bits(item_t)-1:0]   rd_vec;
    logic                       q_empty;
    logic [$clog2(DEPTH+1)-1:0] q_count;
    logic                       exp_ones;

    assign exp_ones    = (value_bits[30:23] == 8'hFF);
    assign cls.cmd     = command;
    assign cls.value   = value_bits;
    assign cls.first   = first;
    assign cls.last    = last;
    assign cls.is_nan  = exp_ones && (value_bits[22:0] != '0);
    assign cls.is_inf  = exp_ones && (value_bits[22:0] == '0);
    assign cls.is_tiny = (value_bits[30:23] == 8'h00);

    amq_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls),
        .full    (full),
        .rd_en   (item_pop),
        .rd_data (rd_vec),
        .empty   (q_empty),
        .count   (q_count)
    );

    assign item_valid = !q_empty && (q_count != '0);
    assign item       = item_t'(rd_vec);

endmodule

`default_nettype wire

>>> rtl/core/amq_div.sv
// ----------------------------------------------------------------------------
// amq_div
// Radix-2 restoring divider for positive normal single precision operands,
// round to nearest even. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module amq_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] a_bits,
    input  wire logic [31:0] b_bits,
    output logic             done,
    output logic [31:0]      q_bits
);

    logic              busy_reg;
    logic [4:0]        cnt_reg;
    logic [25:0]       rem_reg;
    logic [24:0]       quo_reg;
    logic [23:0]       mb_reg;
    logic signed [9:0] exp_reg;
    logic              done_reg;
    logic [31:0]       res_reg;

    logic [23:0]       ma, mb;
    logic              pre_sh;
    logic              ge;
    logic              rnd_up;
    logic [24:0]       mant_sum;
    logic signed [9:0] exp_fin;

    assign ma     = {1'b1, a_bits[22:0]};
    assign mb     = {1'b1, b_bits[22:0]};
    assign pre_sh = (ma < mb);
    assign ge     = (rem_reg >= {2'b00, mb_reg});

    assign rnd_up   = quo_reg[0] && ((rem_reg != '0) || quo_reg[1]);
    assign mant_sum = {1'b0, quo_reg[24:1]} + {24'd0, rnd_up};
    assign exp_fin  = exp_reg + $signed({9'd0, mant_sum[24]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd25;
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mb_reg  <= mb;
            quo_reg <= '0;
            rem_reg <= pre_sh ? {1'b0, ma, 1'b0} : {2'b00, ma};
            exp_reg <= $signed({2'b00, a_bits[30:23]}) - $signed({2'b00, b_bits[30:23]})
                       + 10'sd127 - $signed({9'd0, pre_sh});
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            quo_reg <= {quo_reg[23:0], ge};
            if (ge)
            begin
                rem_reg <= {rem_reg - {2'b00, mb_reg}} << 1;
            end
            else
            begin
                rem_reg <= rem_reg << 1;
            end
        end
        else if (busy_reg)
        begin
            res_reg <= {1'b0, exp_fin[7:0], mant_sum[22:0]};
        end
    end

    assign done   = done_reg;
    assign q_bits = res_reg;

endmodule

`default_nettype wire

>>> rtl/core/amq_back.sv
// ----------------------------------------------------------------------------
// amq_back
// Executes queued items: running absmax, scale and reciprocal, and the
// two-stage multiply / round / clamp path for quantize items.
// ----------------------------------------------------------------------------
`default_nettype none

module amq_back #(
    parameter int OUT_DEPTH = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_pop,
    input  wire amq_pkg::item_t                item,
    input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                               res_wr,
    output amq_pkg::result_t                   res
);

    import amq_pkg::*;

    localparam int OCW = $clog2(OUT_DEPTH+1);

    back_state_t state_reg, state_next;

    logic [31:0] max_reg;
    logic [31:0] scale_reg;
    logic [31:0] inv_reg;

    logic        div_start;
    logic [31:0] div_a, div_b;
    logic        div_done;
    logic [31:0] div_q;

    logic        room;
    logic        pop_g, pop_q;
    logic [31:0] base_max, new_max, cap;
    logic        cap_inf;
    logic [31:0] scale_fix;

    // quantize stage 1
    logic        v1_reg;
    logic [47:0] prod_reg;
    logic [8:0]  esum_reg;
    logic        neg_reg, nan_reg, inf_reg, tiny_reg, last_reg;
    logic [31:0] sc1_reg;

    amq_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .a_bits (div_a),
        .b_bits (div_b),
        .done   (div_done),
        .q_bits (div_q)
    );

    assign room  = ({1'b0, out_count} + {{OCW{1'b0}}, v1_reg}) < (OCW+1)'(OUT_DEPTH);
    assign pop_g = (state_reg == BK_RUN) && item_valid && (item.cmd == CMD_GATHER);
    assign pop_q = (state_reg == BK_RUN) && item_valid && (item.cmd == CMD_QUANT) && room;
    assign item_pop = pop_g || pop_q;

    // Absolute values compare as unsigned bit patterns
    always_comb
    begin
        base_max = item.first ? 32'd0 : max_reg;
        new_max  = base_max;
        if (!item.is_nan && ({1'b0, item.value[30:0]} > base_max))
        begin
            new_max = {1'b0, item.value[30:0]};
        end
        cap     = (new_max < FP_EPS) ? FP_EPS : new_max;
        cap_inf = (cap[30:23] == 8'hFF);
        scale_fix = (div_q < FP_EPS) ? FP_ONE : div_q;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_RUN:
            begin
                if (pop_g && item.last && !cap_inf)
                begin
                    state_next = BK_DIV_SCALE;
                end
            end
            BK_DIV_SCALE:
            begin
                if (div_done)
                begin
                    state_next = BK_DIV_INV;
                end
            end
            BK_DIV_INV:
            begin
                if (div_done)
                begin
                    state_next = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_a     = cap;
        div_b     = FP_QMAX;
        case (state_reg)
            BK_RUN:
            begin
                div_start = pop_g && item.last && !cap_inf;
            end
            BK_DIV_SCALE:
            begin
                div_start = div_done;
                div_a     = FP_ONE;
                div_b     = scale_fix;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_RUN;
            max_reg   <= 32'd0;
            scale_reg <= FP_ONE;
            inv_reg   <= FP_ONE;
            v1_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= pop_q;
            if (pop_g)
            begin
                max_reg <= new_max;
                if (item.last && cap_inf)
                begin
                    scale_reg <= FP_ONE;
                    inv_reg   <= FP_ONE;
                end
            end
            if ((state_reg == BK_DIV_SCALE) && div_done)
            begin
                scale_reg <= scale_fix;
            end
            if ((state_reg == BK_DIV_INV) && div_done)
            begin
                inv_reg <= div_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_q)
        begin
            prod_reg <= {24'd0, 1'b1, item.value[22:0]} * {24'd0, 1'b1, inv_reg[22:0]};
            esum_reg <= {1'b0, item.value[30:23]} + {1'b0, inv_reg[30:23]};
            neg_reg  <= item.value[31];
            nan_reg  <= item.is_nan;
            inf_reg  <= item.is_inf;
            tiny_reg <= item.is_tiny;
            last_reg <= item.last;
            sc1_reg  <= scale_reg;
        end
    end

    // Stage 2: round product to single precision, then to an integer
    logic signed [9:0] e_a, e_b;
    logic [47:0]       m_n;
    logic [23:0]       f_t;
    logic              f_up;
    logic [24:0]       f_s;
    logic [23:0]       f_m;
    logic [2:0]        sh;
    logic [31:0]       fx;
    logic [6:0]        t_int;
    logic              r_up;
    logic [7:0]        r_mag;
    logic              big, sat;
    logic [7:0]        q_val;

    always_comb
    begin
        e_a  = $signed({1'b0, esum_reg}) - 10'sd254 + $signed({9'd0, prod_reg[47]});
        m_n  = prod_reg[47] ? prod_reg : {prod_reg[46:0], 1'b0};
        f_t  = m_n[47:24];
        f_up = m_n[23] && ((m_n[22:0] != '0) || f_t[0]);
        f_s  = {1'b0, f_t} + {24'd0, f_up};
        f_m  = f_s[24] ? 24'h80_0000 : f_s[23:0];
        e_b  = e_a + $signed({9'd0, f_s[24]});
        big  = (e_b >= 10'sd7);
        sh   = 3'((10'sd6 - e_b) & 10'sd7);
        fx   = {f_m, 8'd0} >> sh;
        t_int = fx[31:25];
        r_up = fx[24] && ((fx[23:0] != '0) || t_int[0]);
        r_mag = (e_b < -10'sd1) ? 8'd0 : ({1'b0, t_int} + {7'd0, r_up});
        sat  = inf_reg || big || r_mag[7];
        q_val = neg_reg ? (8'd0 - r_mag) : r_mag;

        res.scale_bits = sc1_reg;
        res.last_out   = last_reg;
        res.sat_pos    = 1'b0;
        res.sat_neg    = 1'b0;
        if (nan_reg || (tiny_reg && !inf_reg))
        begin
            res.quantized = 8'd0;
        end
        else if (sat)
        begin
            res.quantized = neg_reg ? Q_NEG_MAX : Q_POS_MAX;
            res.sat_pos   = !neg_reg;
            res.sat_neg   = neg_reg;
        end
        else
        begin
            res.quantized = q_val;
        end
    end

    assign res_wr = v1_reg;

endmodule

`default_nettype wire

>>> rtl/core/absmax_int8_activation_quantizer_core.sv
// ----------------------------------------------------------------------------
// absmax_int8_activation_quantizer_core
// Two-pass symmetric int8 absmax quantizer for fp32 activations.
// ----------------------------------------------------------------------------
// Input channel: push/full. Each item carries command (0 gather, 1 quantize),
// value_bits (fp32), first and last. Result channel: empty/pop; one result
// per quantize item, oldest on the ports while empty is low.
// Gather items update the running absmax and produce no result; a gather
// item with last set forms scale = max(absmax, 1e-8)/127 and its reciprocal
// in the shared serial divider, one divide after the other, and the back
// end stalls until both are done. An infinite absmax, or a scale below 1e-8,
// gives scale and reciprocal 1.0. Other items sustain one per cycle while
// the result queue has room. After the input queue, a quantize result passes
// the multiply register, then round/clamp into the result queue.
// If the receiver stalls, the result queue fills, the back end stops taking
// items, and full rises once the input queue is also full.
// Reset clears both queues, sets absmax to 0.0 and scale and reciprocal to
// 1.0; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module absmax_int8_activation_quantizer_core #(
    parameter int IN_DEPTH  = 4,
    parameter int OUT_DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              command,
    input  wire logic [31:0]       value_bits,
    input  wire logic              first,
    input  wire logic              last,
    output logic                   empty,
    input  wire logic              pop,
    output logic signed [7:0]      quantized,
    output logic                   sat_pos,
    output logic                   sat_neg,
    output logic [31:0]            scale_bits,
    output logic                   last_out
);

    import amq_pkg::*;

    item_t                          item;
    logic                           item_valid;
    logic                           item_pop;
    result_t                        res_in;
    result_t                        res_out;
    logic [$bits(result_t)-1:0]     res_vec;
    logic                           res_wr;
    logic                           res_full;
    logic [$clog2(OUT_DEPTH+1)-1:0] res_count;

    amq_front #(
        .DEPTH (IN_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .value_bits (value_bits),
        .first      (first),
        .last       (last),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item)
    );

    amq_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item),
        .out_count  (res_count),
        .res_wr     (res_wr),
        .res        (res_in)
    );

    amq_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr && !res_full),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_vec),
        .empty   (empty),
        .count   (res_count)
    );

    assign res_out    = result_t'(res_vec);
    assign quantized  = $signed(res_out.quantized);
    assign sat_pos    = res_out.sat_pos;
    assign sat_neg    = res_out.sat_neg;
    assign scale_bits = res_out.scale_bits;
    assign last_out   = res_out.last_out;

endmodule

`default_nettype wire

>>> rtl/core/amq_checker.sv
// ----------------------------------------------------------------------------
// amq_checker
// Port-level checks on the result channel of the quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

module amq_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              empty,
    input wire logic              pop,
    input wire logic signed [7:0] quantized,
    input wire logic              sat_pos,
    input wire logic              sat_neg,
    input wire logic [31:0]       scale_bits
);

    // code never reaches the asymmetric minimum
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (quantized != -8'sd128))
        else $error("quantized code out of symmetric range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && sat_pos) |-> (quantized == 8'sd127 && !sat_neg))
        else $error("positive saturation without clamp to +127");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && sat_neg) |-> (quantized == -8'sd127))
        else $error("negative saturation without clamp to -127");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(quantized) && $stable(scale_bits)))
        else $error("stalled result changed");

endmodule

bind absmax_int8_activation_quantizer_core amq_checker u_amq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .quantized  (quantized),
    .sat_pos    (sat_pos),
    .sat_neg    (sat_neg),
    .scale_bits (scale_bits)
);

`default_nettype wire

>>> sim/absmax_int8_activation_quantizer_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// absmax_int8_activation_quantizer_core_checker
// Watches both queue channels of the quantizer, predicts each quantize
// result from a bit-exact single precision model and compares field by field.
// ----------------------------------------------------------------------------

module absmax_int8_activation_quantizer_core_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic        command,
    input  wire logic [31:0] value_bits,
    input  wire logic        first,
    input  wire logic        last,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [7:0]  quantized,
    input  wire logic        sat_pos,
    input  wire logic        sat_neg,
    input  wire logic [31:0] scale_bits,
    input  wire logic        last_out,
    output int               errors,
    output int               pending
);

    import amq_pkg::*;

    logic [31:0] max_abs_q;
    logic [31:0] scale_q;
    logic [31:0] inv_scale_q;
    result_t     quant_results[$];

    function automatic logic f32_is_nan(logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 0);
    endfunction

    function automatic real f32_to_real(logic [31:0] b);
        logic [10:0] e;
        if (b[30:23] == 8'hFF)
            return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'b0});
        if (b[30:23] == 8'h00)
        begin
            // subnormal or zero: mantissa times 2^-149
            if (b[31])
                return -(real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000));
            return real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
        end
        e = 11'(b[30:23]) + 11'd896;
        return $bitstoreal({b[31], e, b[22:0], 29'b0});
    endfunction

    // Round a double to single precision, nearest even, with subnormals.
    function automatic logic [31:0] real_to_f32(real r);
        logic [63:0] d;
        logic [52:0] sig;
        logic [52:0] kept;
        logic [52:0] rem;
        logic [52:0] half;
        int          ef;
        int          shift;
        logic [31:0] mag;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? 32'h7FC0_0000 : {d[63], 31'h7F80_0000};
        if (d[62:52] == 11'h000)
            return {d[63], 31'h0};
        sig = {1'b1, d[51:0]};
        ef = int'(d[62:52]) - 1023 + 127;
        shift = (ef >= 1) ? 29 : 29 + 1 - ef;
        if (shift > 53)
            return {d[63], 31'h0};
        kept = sig >> shift;
        rem = sig & ((53'd1 << shift) - 1);
        half = 53'd1 << (shift - 1);
        if (rem > half || (rem == half && kept[0]))
            kept = kept + 1;
        if (ef >= 1)
        begin
            if (ef >= 255)
                return {d[63], 31'h7F80_0000};
            mag = (32'(ef - 1) << 23) + 32'(kept);
        end
        else
            mag = 32'(kept);
        if (mag >= 32'h7F80_0000)
            mag = 32'h7F80_0000;
        return {d[63], mag[30:0]};
    endfunction

    task automatic gather_element(logic [31:0] vb, logic f, logic l);
        real cap;
        logic [31:0] s;
        if (f)
            max_abs_q = 32'h0;
        if (!f32_is_nan(vb) && f32_to_real(max_abs_q) < f32_to_real({1'b0, vb[30:0]}))
            max_abs_q = {1'b0, vb[30:0]};
        if (l)
        begin
            cap = f32_to_real(max_abs_q);
            if (cap < f32_to_real(FP_EPS))
                cap = f32_to_real(FP_EPS);
            s = real_to_f32(cap / f32_to_real(FP_QMAX));
            if (s[30:23] == 8'hFF || f32_to_real(s) < f32_to_real(FP_EPS))
                s = FP_ONE;
            scale_q = s;
            inv_scale_q = real_to_f32(1.0 / f32_to_real(s));
        end
    endtask

    function automatic result_t quantize_element(logic [31:0] vb, logic l);
        result_t     res;
        logic [31:0] prod;
        real         mag;
        int          r;
        int          q;
        res = '0;
        res.scale_bits = scale_q;
        res.last_out = l;
        prod = real_to_f32(f32_to_real(vb) * f32_to_real(inv_scale_q));
        if (f32_is_nan(prod))
            return res;
        mag = f32_to_real({1'b0, prod[30:0]});
        if (mag >= 128.0)
            r = 128;
        else
        begin
            r = $rtoi(mag);
            if ((mag - real'(r)) > 0.5 || ((mag - real'(r)) == 0.5 && r[0]))
                r = r + 1;
        end
        q = prod[31] ? -r : r;
        if (q > 127)
        begin
            q = 127;
            res.sat_pos = 1'b1;
        end
        else if (q < -127)
        begin
            q = -127;
            res.sat_neg = 1'b1;
        end
        res.quantized = 8'(q);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            max_abs_q = 32'h0;
            scale_q = FP_ONE;
            inv_scale_q = FP_ONE;
            quant_results.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (quant_results.size() == 0)
                begin
                    $display("%0t: result with none expected: q=%0d scale=%h", $time,
                             $signed(quantized), scale_bits);
                    errors = errors + 1;
                end
                else
                begin
                    want = quant_results.pop_front();
                    if (quantized !== want.quantized || sat_pos !== want.sat_pos ||
                        sat_neg !== want.sat_neg || scale_bits !== want.scale_bits ||
                        last_out !== want.last_out)
                    begin
                        $display("%0t: mismatch expected q=%0d sp=%b sn=%b scale=%h last=%b",
                                 $time, $signed(want.quantized), want.sat_pos, want.sat_neg,
                                 want.scale_bits, want.last_out);
                        $display("%0t:          actual   q=%0d sp=%b sn=%b scale=%h last=%b",
                                 $time, $signed(quantized), sat_pos, sat_neg, scale_bits,
                                 last_out);
                        errors = errors + 1;
                    end
                end
            end
            if (push && !full)
            begin
                if (command == CMD_GATHER)
                    gather_element(value_bits, first, last);
                else
                    quant_results = {quant_results, quantize_element(value_bits, last)};
            end
            pending = quant_results.size();
        end
    end

endmodule

>>> sim/absmax_int8_activation_quantizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// absmax_int8_activation_quantizer_core_tb
// Drives gather and quantize passes into the quantizer under random idling
// and back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------

module absmax_int8_activation_quantizer_core_tb;
    import amq_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        command = CMD_GATHER;
    logic [31:0] value_bits = '0;
    logic        first = 1'b0;
    logic        last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  quantized;
    logic        sat_pos;
    logic        sat_neg;
    logic [31:0] scale_bits;
    logic        last_out;
    int          errors;
    int          pending;

    int          send_idle_pct = 9;
    int          recv_idle_pct = 64;
    logic        hold_req = 1'b0;
    logic [31:0] tensor_vals[$];

    always #5 clk = ~clk;

    absmax_int8_activation_quantizer_core i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .command(command),
        .value_bits(value_bits), .first(first), .last(last), .empty(empty),
        .pop(pop), .quantized(quantized), .sat_pos(sat_pos), .sat_neg(sat_neg),
        .scale_bits(scale_bits), .last_out(last_out)
    );

    absmax_int8_activation_quantizer_core_checker i_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .command(command),
        .value_bits(value_bits), .first(first), .last(last), .empty(empty),
        .pop(pop), .quantized(quantized), .sat_pos(sat_pos), .sat_neg(sat_neg),
        .scale_bits(scale_bits), .last_out(last_out), .errors(errors),
        .pending(pending)
    );

    // Receiver: pop at random, or hold off for a long stretch on request.
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                pop <= 1'b0;
                repeat (200) @(negedge clk);
                held = 1'b1;
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(logic c, logic [31:0] v, logic f, logic l);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
        repeat (gap)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        command <= c;
        value_bits <= v;
        first <= f;
        last <= l;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    function automatic logic [31:0] special_value();
        case ($urandom_range(7))
            0: return 32'h7FC0_0000 | ($urandom & 32'h803F_FFFF);
            1: return 32'h7F80_0000;
            2: return 32'hFF80_0000;
            3: return 32'h0000_0000;
            4: return 32'h8000_0000;
            5: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
            6: return {1'($urandom_range(1)), 8'hFE, 23'($urandom)};
            default: return {1'($urandom_range(1)), 8'h7F, 23'h0};
        endcase
    endfunction

    function automatic logic [31:0] tensor_value(int exp_base);
        int e;
        case ($urandom_range(19))
            0: return $urandom;
            1: return special_value();
            default:
            begin
                e = exp_base - $urandom_range(0, 8);
                if (e < 0)
                    e = 0;
                return {1'($urandom_range(1)), 8'(e), 23'($urandom)};
            end
        endcase
    endfunction

    // One gather pass followed by a quantize pass over related values.
    task automatic run_tensor();
        int          n;
        int          m;
        int          exp_base;
        logic [31:0] v;
        n = $urandom_range(1, 6);
        m = $urandom_range(1, 10);
        case ($urandom_range(9))
            0: exp_base = $urandom_range(0, 254);
            1: exp_base = $urandom_range(90, 100);
            default: exp_base = $urandom_range(110, 150);
        endcase
        tensor_vals.delete();
        for (int i = 0; i < n; i++)
        begin
            v = tensor_value(exp_base);
            tensor_vals = {tensor_vals, v};
            send_item(CMD_GATHER, v, i == 0, i == n - 1);
        end
        for (int i = 0; i < m; i++)
        begin
            v = tensor_vals[$urandom_range(n - 1)];
            case ($urandom_range(5))
                0: v = tensor_value(exp_base);
                1: v = {v[31], v[30:23] + 8'd1, v[22:0]};
                2: v = {1'($urandom_range(1)), v[30:0]};
                default: ;
            endcase
            send_item(CMD_QUANT, v, 1'($urandom_range(1)),
                      i == m - 1 || $urandom_range(7) == 0);
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("absmax_int8_activation_quantizer_core_tb NOT OK");
        $finish;
    end

    initial
    begin
        int sent;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Quantize with the reset reciprocal, ties and saturation at scale 1.0
        send_item(CMD_QUANT, 32'h4020_0000, 1'b0, 1'b0);
        send_item(CMD_QUANT, 32'h4060_0000, 1'b1, 1'b1);
        send_item(CMD_QUANT, 32'hBF00_0000, 1'b0, 1'b0);
        send_item(CMD_QUANT, 32'h42FF_0000, 1'b0, 1'b0);
        send_item(CMD_QUANT, 32'hC2FF_0000, 1'b0, 1'b1);
        send_item(CMD_QUANT, 32'h42FE_0000, 1'b0, 1'b0);
        send_item(CMD_QUANT, 32'h7FC0_0001, 1'b0, 1'b0);
        send_item(CMD_QUANT, 32'h7F80_0000, 1'b0, 1'b0);
        send_item(CMD_QUANT, 32'hFF80_0000, 1'b0, 1'b0);
        send_item(CMD_QUANT, 32'hFFFF_FFFF, 1'b1, 1'b1);
        // Tiny maximum falls back to scale 1.0
        send_item(CMD_GATHER, 32'h0000_0001, 1'b1, 1'b1);
        send_item(CMD_QUANT, 32'h3F40_0000, 1'b0, 1'b1);
        // NaN ignored, regular scale from 254
        send_item(CMD_GATHER, 32'h7FFF_FFFF, 1'b1, 1'b0);
        send_item(CMD_GATHER, 32'hC37E_0000, 1'b0, 1'b1);
        send_item(CMD_QUANT, 32'h4300_0000, 1'b0, 1'b0);
        send_item(CMD_QUANT, 32'hC37E_0000, 1'b0, 1'b0);
        send_item(CMD_QUANT, 32'h7FC0_0000, 1'b0, 1'b1);
        // Infinite maximum falls back to scale 1.0
        send_item(CMD_GATHER, 32'h3F80_0000, 1'b1, 1'b0);
        send_item(CMD_GATHER, 32'hFF80_0000, 1'b0, 1'b1);
        send_item(CMD_QUANT, 32'h4330_0000, 1'b0, 1'b1);
        // Largest finite maximum
        send_item(CMD_GATHER, 32'h7F7F_FFFF, 1'b1, 1'b1);
        send_item(CMD_QUANT, 32'hFF7F_FFFF, 1'b0, 1'b1);
        push <= 1'b0;
        // Pause until every expected result has come
        wait (pending == 0);
        @(negedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 9 : 0;
            sent = 0;
            while (sent < 200)
            begin
                if (phase == 2 && sent >= 40 && sent < 51)
                    hold_req = 1'b1;
                run_tensor();
                sent = sent + tensor_vals.size() + 5;
            end
        end
        push <= 1'b0;

        wait (pending == 0);
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("absmax_int8_activation_quantizer_core_tb OK");
        else
            $display("absmax_int8_activation_quantizer_core_tb NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/amq_pkg.sv
rtl/core/amq_fifo.sv
rtl/core/amq_front.sv
rtl/core/amq_div.sv
rtl/core/amq_back.sv
rtl/core/absmax_int8_activation_quantizer_core.sv
rtl/core/amq_checker.sv
sim/absmax_int8_activation_quantizer_core_checker.sv
sim/absmax_int8_activation_quantizer_core_tb.sv
